>>> sv/wfc_pkg.sv
// Package for the waterfall colour mapper: widths, codes, palette breakpoints,
// and the command and status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package wfc_pkg;

  localparam int STORE_DEPTH   = 4096;
  localparam int FRACTION_BITS = 8;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int IDX_W   = 12;
  localparam int SMP_W   = 17;
  localparam int PAN_W   = 12;
  localparam int LW_W    = 13;
  localparam int MODE_W  = 2;
  localparam int V_W     = SMP_W + 1;
  localparam int EW_W    = $clog2(STORE_DEPTH + 1);
  localparam int CMP_W   = (EW_W > LW_W) ? EW_W : LW_W;
  localparam int SUM_W   = 29;
  localparam int LIM_W   = 30;
  localparam int LOW_SUB = 5 << FRACTION_BITS;
  localparam int SPAN    = 55 << FRACTION_BITS;
  localparam int SPAN_W  = $clog2(SPAN + 1);
  localparam int RNG_W   = (SPAN_W > 17) ? SPAN_W : 17;
  localparam int QUO_W   = SUM_W;
  localparam int CNT_W   = $clog2(QUO_W + 1);
  localparam int FRAC_W  = 17;
  localparam int LP_W    = 17;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LIM_W-1:0]  lim_t;
  typedef logic [RNG_W-1:0]  rng_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [FRAC_W-1:0] frac_t;

  localparam logic [SMP_W-1:0] MAN_LOW_RST  = SMP_W'(-35840);
  localparam logic [SMP_W-1:0] MAN_HIGH_RST = SMP_W'(-15360);
  localparam logic [LW_W-1:0]  LW_RST       = LW_W'(4096);

  localparam cmp_t  DEPTH_CMP  = cmp_t'(STORE_DEPTH);
  localparam cmp_t  ONE_CMP    = cmp_t'(1);
  localparam lim_t  LOW_SUB_L  = lim_t'(LOW_SUB);
  localparam lim_t  HIGH_ADD_L = lim_t'(SPAN - LOW_SUB);
  localparam cnt_t  MEAN_STEPS = cnt_t'(QUO_W);
  localparam cnt_t  FRAC_STEPS = cnt_t'(FRAC_W - 1);
  localparam frac_t ONE16      = frac_t'(65536);
  localparam logic [18:0] TOP_BASE = 19'h40000;

  // k/9 in Q0.16 for k = 2,3,4,5,7,8
  localparam frac_t PAL_BRK [0:5] = '{
    17'd14564, 17'd21845, 17'd29127, 17'd36409, 17'd50972, 17'd58254
  };

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_PIXEL = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AUTO_LEVEL   = 3'd0,
    REG_MANUAL_LOW   = 3'd1,
    REG_MANUAL_HIGH  = 3'd2,
    REG_LEVEL_OFFSET = 3'd3,
    REG_PAN_OFFSET   = 3'd4,
    REG_LINE_WIDTH   = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CLIP_BLACK,
    CLIP_YELLOW,
    CLIP_ZERO,
    CLIP_FULL,
    CLIP_DIV
  } clip_t;

  typedef enum logic [2:0] {
    SEG_BLUE_UP,
    SEG_GREEN_UP,
    SEG_BLUE_DOWN,
    SEG_RED_UP,
    SEG_GREEN_DOWN,
    SEG_MAGENTA,
    SEG_WHITE
  } pal_seg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDATA,
    ST_MEAN,
    ST_LIMIT,
    ST_CLIP,
    ST_FRAC,
    ST_PAL1,
    ST_PAL2,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic mean_start;
    logic v_load;
    logic lim_load;
    logic clip_load;
    logic frac_start;
    logic f_take;
    logic pal_a;
    logic pal_b;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic  auto_level;
    logic  div_busy;
    clip_t clip;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/wfc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module wfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> sv/wfc_div.sv
// Restoring divider, one quotient bit per cycle, shared by the line mean
// and the palette fraction. Depends on wfc_pkg.
`default_nettype none

module wfc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [wfc_pkg::CNT_W-1:0] steps,
  input  logic [wfc_pkg::QUO_W-1:0] dvd,
  input  logic [wfc_pkg::RNG_W-1:0] rem_init,
  input  logic [wfc_pkg::RNG_W-1:0] den,
  output logic [wfc_pkg::QUO_W-1:0] quo,
  output logic [wfc_pkg::RNG_W-1:0] rem,
  output logic                      busy
);

  logic [wfc_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [wfc_pkg::RNG_W-1:0] rem_r, rem_nxt;
  logic [wfc_pkg::RNG_W-1:0] den_r, den_nxt;
  logic [wfc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [wfc_pkg::RNG_W:0]   trial;
  logic [wfc_pkg::RNG_W:0]   sub;

  always_comb begin
    trial   = {rem_r, quo_r[wfc_pkg::QUO_W-1]};
    sub     = trial - {1'b0, den_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dvd;
      rem_nxt = rem_init;
      den_nxt = den;
      cnt_nxt = steps;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - wfc_pkg::cnt_t'(1);
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = sub[wfc_pkg::RNG_W-1:0];
        quo_nxt = {quo_r[wfc_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[wfc_pkg::RNG_W-1:0];
        quo_nxt = {quo_r[wfc_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign busy = (cnt_r != '0);

endmodule

`default_nettype wire

>>> sv/wfc_dp.sv
// Datapath: config registers, sample store, running sum, limits, clipping,
// divider and palette. Depends on wfc_pkg, wfc_ram and wfc_div.
`default_nettype none

module wfc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wfc_pkg::cmd_t                  cmd,
  output wfc_pkg::sts_t                  sts,
  input  logic [wfc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           cfg_valid,
  input  logic [wfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wfc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [wfc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // config
  logic                      auto_level_r;
  logic [wfc_pkg::SMP_W-1:0] manual_low_r;
  logic [wfc_pkg::SMP_W-1:0] manual_high_r;
  logic [wfc_pkg::SMP_W-1:0] level_offset_r;
  logic [wfc_pkg::PAN_W-1:0] pan_offset_r;
  logic [wfc_pkg::LW_W-1:0]  line_width_r;

  logic [wfc_pkg::IDX_W-1:0] idx;
  logic [wfc_pkg::SMP_W-1:0] smp;
  logic [wfc_pkg::IDX_W:0]   pix_sum;
  wfc_pkg::addr_t            ram_addr;
  logic [wfc_pkg::SMP_W-1:0] ram_rdata;
  wfc_pkg::cmp_t             lw_ext;
  wfc_pkg::cmp_t             eff_w;
  logic                      in_slot;

  logic [wfc_pkg::SUM_W-1:0] sum_r;
  logic [wfc_pkg::SUM_W-1:0] sum_mag;
  logic                      neg_r;

  logic                      div_start;
  wfc_pkg::cnt_t             div_steps;
  logic [wfc_pkg::QUO_W-1:0] div_dvd;
  wfc_pkg::rng_t             div_rem_init;
  wfc_pkg::rng_t             div_den;
  logic [wfc_pkg::QUO_W-1:0] div_quo;
  wfc_pkg::rng_t             div_rem;
  logic                      div_busy;

  logic signed [wfc_pkg::V_W-1:0]   v_r;
  logic signed [wfc_pkg::LIM_W-1:0] v_ext;
  logic signed [wfc_pkg::LIM_W-1:0] low_r, high_r;
  logic        [wfc_pkg::LIM_W-1:0] low_nxt, high_nxt;
  logic        [wfc_pkg::LIM_W-1:0] off_ext;
  logic        [wfc_pkg::LIM_W-1:0] q_rnd;
  logic        [wfc_pkg::LIM_W-1:0] mean;
  logic        [wfc_pkg::LIM_W-1:0] diff;
  logic        [wfc_pkg::LIM_W-1:0] rng;
  wfc_pkg::clip_t                   clip;

  wfc_pkg::frac_t                  f_r;
  wfc_pkg::frac_t                  seg_base;
  wfc_pkg::pal_seg_t               seg, seg_r;
  logic                            seg_half;
  wfc_pkg::frac_t                  d;
  logic [20:0]                     d9;
  logic [20:0]                     lp_raw;
  logic [wfc_pkg::LP_W-1:0]        lp, lp_r;
  logic [26:0]                     p_up, p_dn, p_top;
  logic [wfc_pkg::CH_W-1:0]        up, dn, r_top, g_top;
  logic [wfc_pkg::CH_W-1:0]        red, green, blue;
  logic [wfc_pkg::PIX_W-1:0]       pix_r;
  logic [wfc_pkg::OUT_DATA_W-1:0]  out_data_r;

  function automatic logic [26:0] mul255(input logic [18:0] x);
    return {x, 8'b0} - {8'b0, x};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_level_r   <= 1'b0;
      manual_low_r   <= wfc_pkg::MAN_LOW_RST;
      manual_high_r  <= wfc_pkg::MAN_HIGH_RST;
      level_offset_r <= '0;
      pan_offset_r   <= '0;
      line_width_r   <= wfc_pkg::LW_RST;
    end else if (cfg_valid) begin
      case (wfc_pkg::cfg_reg_t'(cfg_index))
        wfc_pkg::REG_AUTO_LEVEL:   auto_level_r   <= cfg_data[0];
        wfc_pkg::REG_MANUAL_LOW:   manual_low_r   <= cfg_data[wfc_pkg::SMP_W-1:0];
        wfc_pkg::REG_MANUAL_HIGH:  manual_high_r  <= cfg_data[wfc_pkg::SMP_W-1:0];
        wfc_pkg::REG_LEVEL_OFFSET: level_offset_r <= cfg_data[wfc_pkg::SMP_W-1:0];
        wfc_pkg::REG_PAN_OFFSET:   pan_offset_r   <= cfg_data[wfc_pkg::PAN_W-1:0];
        wfc_pkg::REG_LINE_WIDTH:   line_width_r   <= cfg_data[wfc_pkg::LW_W-1:0];
        default: ;
      endcase
    end
  end

  // store access and running sum
  assign idx     = in_tdata[wfc_pkg::IDX_W-1:0];
  assign smp     = in_tdata[wfc_pkg::IDX_W+wfc_pkg::SMP_W-1:wfc_pkg::IDX_W];
  assign pix_sum = {1'b0, idx} + {1'b0, pan_offset_r};

  always_comb begin
    if (cmd.load) begin
      ram_addr = wfc_pkg::addr_t'(idx);
    end else begin
      ram_addr = wfc_pkg::addr_t'(pix_sum);
    end
    lw_ext = wfc_pkg::cmp_t'(line_width_r);
    if (line_width_r == '0) begin
      eff_w = wfc_pkg::ONE_CMP;
    end else if (lw_ext > wfc_pkg::DEPTH_CMP) begin
      eff_w = wfc_pkg::DEPTH_CMP;
    end else begin
      eff_w = lw_ext;
    end
    in_slot = (wfc_pkg::cmp_t'(idx) < eff_w);
  end

  wfc_ram #(
    .WIDTH (wfc_pkg::SMP_W),
    .DEPTH (wfc_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .addr  (ram_addr),
    .wdata (smp),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (cmd.clear) begin
      sum_r <= '0;
    end else if (cmd.load && in_slot) begin
      sum_r <= sum_r + {{(wfc_pkg::SUM_W-wfc_pkg::SMP_W){smp[wfc_pkg::SMP_W-1]}}, smp};
    end
  end

  // divider operands: line mean or palette fraction
  assign sum_mag   = sum_r[wfc_pkg::SUM_W-1] ? (~sum_r + {{(wfc_pkg::SUM_W-1){1'b0}}, 1'b1})
                                             : sum_r;
  assign div_start = cmd.mean_start | cmd.frac_start;

  always_comb begin
    if (cmd.mean_start) begin
      div_steps    = wfc_pkg::MEAN_STEPS;
      div_dvd      = sum_mag;
      div_rem_init = '0;
      div_den      = wfc_pkg::rng_t'(eff_w);
    end else begin
      div_steps    = wfc_pkg::FRAC_STEPS;
      div_dvd      = '0;
      div_rem_init = diff[wfc_pkg::RNG_W-1:0];
      div_den      = rng[wfc_pkg::RNG_W-1:0];
    end
  end

  wfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .steps    (div_steps),
    .dvd      (div_dvd),
    .rem_init (div_rem_init),
    .den      (div_den),
    .quo      (div_quo),
    .rem      (div_rem),
    .busy     (div_busy)
  );

  always_ff @(posedge clk) begin
    if (cmd.mean_start) begin
      neg_r <= sum_r[wfc_pkg::SUM_W-1];
    end
  end

  // limits; negative sums round the mean towards minus infinity
  always_comb begin
    off_ext = {{(wfc_pkg::LIM_W-wfc_pkg::SMP_W){level_offset_r[wfc_pkg::SMP_W-1]}},
               level_offset_r};
    q_rnd   = {1'b0, div_quo} + {{(wfc_pkg::LIM_W-1){1'b0}}, (div_rem != '0)};
    if (neg_r) begin
      mean = ~q_rnd + {{(wfc_pkg::LIM_W-1){1'b0}}, 1'b1};
    end else begin
      mean = {1'b0, div_quo};
    end
    if (auto_level_r) begin
      low_nxt  = mean + off_ext - wfc_pkg::LOW_SUB_L;
      high_nxt = mean + off_ext + wfc_pkg::HIGH_ADD_L;
    end else begin
      low_nxt  = {{(wfc_pkg::LIM_W-wfc_pkg::SMP_W){manual_low_r[wfc_pkg::SMP_W-1]}},
                  manual_low_r};
      high_nxt = {{(wfc_pkg::LIM_W-wfc_pkg::SMP_W){manual_high_r[wfc_pkg::SMP_W-1]}},
                  manual_high_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.v_load) begin
      v_r <= $signed({ram_rdata[wfc_pkg::SMP_W-1], ram_rdata})
           + $signed({level_offset_r[wfc_pkg::SMP_W-1], level_offset_r});
    end
    if (cmd.lim_load) begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  // clipping
  always_comb begin
    v_ext = {{(wfc_pkg::LIM_W-wfc_pkg::V_W){v_r[wfc_pkg::V_W-1]}}, v_r};
    diff  = v_ext - low_r;
    rng   = high_r - low_r;
    if (v_ext < low_r) begin
      clip = wfc_pkg::CLIP_BLACK;
    end else if (v_ext > high_r) begin
      clip = wfc_pkg::CLIP_YELLOW;
    end else if (rng == '0) begin
      clip = wfc_pkg::CLIP_ZERO;
    end else if (diff == rng) begin
      clip = wfc_pkg::CLIP_FULL;
    end else begin
      clip = wfc_pkg::CLIP_DIV;
    end
  end

  // palette, first stage: segment and local position
  always_comb begin
    if (f_r < wfc_pkg::PAL_BRK[0]) begin
      seg = wfc_pkg::SEG_BLUE_UP;    seg_base = '0;                  seg_half = 1'b1;
    end else if (f_r < wfc_pkg::PAL_BRK[1]) begin
      seg = wfc_pkg::SEG_GREEN_UP;   seg_base = wfc_pkg::PAL_BRK[0]; seg_half = 1'b0;
    end else if (f_r < wfc_pkg::PAL_BRK[2]) begin
      seg = wfc_pkg::SEG_BLUE_DOWN;  seg_base = wfc_pkg::PAL_BRK[1]; seg_half = 1'b0;
    end else if (f_r < wfc_pkg::PAL_BRK[3]) begin
      seg = wfc_pkg::SEG_RED_UP;     seg_base = wfc_pkg::PAL_BRK[2]; seg_half = 1'b0;
    end else if (f_r < wfc_pkg::PAL_BRK[4]) begin
      seg = wfc_pkg::SEG_GREEN_DOWN; seg_base = wfc_pkg::PAL_BRK[3]; seg_half = 1'b1;
    end else if (f_r < wfc_pkg::PAL_BRK[5]) begin
      seg = wfc_pkg::SEG_MAGENTA;    seg_base = wfc_pkg::PAL_BRK[4]; seg_half = 1'b0;
    end else begin
      seg = wfc_pkg::SEG_WHITE;      seg_base = wfc_pkg::PAL_BRK[5]; seg_half = 1'b0;
    end
    d      = f_r - seg_base;
    d9     = {1'b0, d, 3'b0} + {4'b0, d};
    lp_raw = seg_half ? {1'b0, d9[20:1]} : d9;
    if (lp_raw > {4'b0, wfc_pkg::ONE16}) begin
      lp = wfc_pkg::ONE16;
    end else begin
      lp = lp_raw[wfc_pkg::LP_W-1:0];
    end
  end

  // palette, second stage: channels
  always_comb begin
    p_up  = mul255({2'b0, lp_r});
    p_dn  = mul255({2'b0, wfc_pkg::ONE16 - lp_r});
    p_top = mul255(wfc_pkg::TOP_BASE - {2'b0, lp_r});
    up    = p_up[23:16];
    dn    = p_dn[23:16];
    g_top = p_up[24:17];
    r_top = p_top[25:18];
    case (seg_r)
      wfc_pkg::SEG_BLUE_UP: begin
        red = '0;     green = '0;     blue = up;
      end
      wfc_pkg::SEG_GREEN_UP: begin
        red = '0;     green = up;     blue = 8'hFF;
      end
      wfc_pkg::SEG_BLUE_DOWN: begin
        red = '0;     green = 8'hFF;  blue = dn;
      end
      wfc_pkg::SEG_RED_UP: begin
        red = up;     green = 8'hFF;  blue = '0;
      end
      wfc_pkg::SEG_GREEN_DOWN: begin
        red = 8'hFF;  green = dn;     blue = '0;
      end
      wfc_pkg::SEG_MAGENTA: begin
        red = 8'hFF;  green = '0;     blue = up;
      end
      wfc_pkg::SEG_WHITE: begin
        red = r_top;  green = g_top;  blue = 8'hFF;
      end
      default: begin
        red = '0;     green = '0;     blue = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clip_load) begin
      case (clip)
        wfc_pkg::CLIP_BLACK:  pix_r <= '0;
        wfc_pkg::CLIP_YELLOW: pix_r <= {8'h00, 8'hFF, 8'hFF};
        wfc_pkg::CLIP_ZERO:   f_r   <= '0;
        wfc_pkg::CLIP_FULL:   f_r   <= wfc_pkg::ONE16;
        default: ;
      endcase
    end
    if (cmd.f_take) begin
      f_r <= {1'b0, div_quo[wfc_pkg::FRAC_W-2:0]};
    end
    if (cmd.pal_a) begin
      seg_r <= seg;
      lp_r  <= lp;
    end
    if (cmd.pal_b) begin
      pix_r <= {blue, green, red};
    end
    if (cmd.out_load) begin
      out_data_r <= pix_r;
    end
  end

  assign out_tdata      = out_data_r;
  assign sts.auto_level = auto_level_r;
  assign sts.div_busy   = div_busy;
  assign sts.clip       = clip;

endmodule

`default_nettype wire

>>> sv/wfc_ctrl.sv
// Controller: sequences one request at a time through the datapath and owns
// the stream handshakes. Depends on wfc_pkg.
`default_nettype none

module wfc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [wfc_pkg::MODE_W-1:0] in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output wfc_pkg::cmd_t              cmd,
  input  wfc_pkg::sts_t              sts
);

  wfc_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wfc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      wfc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (wfc_pkg::mode_t'(in_tuser))
            wfc_pkg::MODE_LOAD:  cmd.load  = 1'b1;
            wfc_pkg::MODE_CLEAR: cmd.clear = 1'b1;
            wfc_pkg::MODE_PIXEL: begin
              cmd.mean_start = sts.auto_level;
              state_nxt      = wfc_pkg::ST_RDATA;
            end
            default: ;
          endcase
        end
      end
      wfc_pkg::ST_RDATA: begin
        cmd.v_load = 1'b1;
        state_nxt  = sts.auto_level ? wfc_pkg::ST_MEAN : wfc_pkg::ST_LIMIT;
      end
      wfc_pkg::ST_MEAN: begin
        if (!sts.div_busy) begin
          state_nxt = wfc_pkg::ST_LIMIT;
        end
      end
      wfc_pkg::ST_LIMIT: begin
        cmd.lim_load = 1'b1;
        state_nxt    = wfc_pkg::ST_CLIP;
      end
      wfc_pkg::ST_CLIP: begin
        cmd.clip_load = 1'b1;
        case (sts.clip)
          wfc_pkg::CLIP_ZERO, wfc_pkg::CLIP_FULL: state_nxt = wfc_pkg::ST_PAL1;
          wfc_pkg::CLIP_DIV: begin
            cmd.frac_start = 1'b1;
            state_nxt      = wfc_pkg::ST_FRAC;
          end
          default: state_nxt = wfc_pkg::ST_PUSH;
        endcase
      end
      wfc_pkg::ST_FRAC: begin
        if (!sts.div_busy) begin
          cmd.f_take = 1'b1;
          state_nxt  = wfc_pkg::ST_PAL1;
        end
      end
      wfc_pkg::ST_PAL1: begin
        cmd.pal_a = 1'b1;
        state_nxt = wfc_pkg::ST_PAL2;
      end
      wfc_pkg::ST_PAL2: begin
        cmd.pal_b = 1'b1;
        state_nxt = wfc_pkg::ST_PUSH;
      end
      wfc_pkg::ST_PUSH: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = wfc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wfc_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> sv/spectrum_waterfall_colormap.sv
// Top level of the waterfall colour mapper.
// Depends on wfc_pkg, wfc_ctrl and wfc_dp (which holds wfc_ram and wfc_div).
//
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  tuser: mode; tdata: index, sample
//  out_     master     out_tvalid/out_tready tdata: red, green, blue
//  cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Load and clear requests are handled in the idle state. A pixel request holds the
// controller through RDATA, LIMIT, CLIP, the 16-step fraction divide in FRAC, PAL1,
// PAL2 and PUSH with manual limits; in auto mode a 29-step divide for the line mean
// comes first, waited out in MEAN. A clipped pixel skips the fraction divide.
// Reset is synchronous; the sample store is not cleared.
// A finished pixel sits in the output register while the next request is taken;
// a second pixel waits for that register to drain.
`default_nettype none

module spectrum_waterfall_colormap (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [wfc_pkg::IN_DATA_W-1:0]  in_tdata,   // index[11:0], sample[28:12]
  input  logic [wfc_pkg::MODE_W-1:0]     in_tuser,   // mode[1:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wfc_pkg::OUT_DATA_W-1:0] out_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wfc_pkg::CFG_DATA_W-1:0] cfg_data
);

  wfc_pkg::cmd_t cmd;
  wfc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  wfc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  wfc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

>>> dv/tb_spectrum_waterfall_colormap.sv
// Self-checking bench for spectrum_waterfall_colormap: drives load, pixel and clear
// requests with random idling on both streams and checks every pixel against an
// in-bench colour predictor. Depends on wfc_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_spectrum_waterfall_colormap;
  import wfc_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 720;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam longint UNIT_Q16   = 65536;
  localparam longint LOW_MARGIN = 5 * 256;
  localparam longint SPAN_Q8    = 55 * 256;
  // palette breakpoints k/9 in Q0.16
  localparam longint BRK2 = 14564;
  localparam longint BRK3 = 21845;
  localparam longint BRK4 = 29127;
  localparam longint BRK5 = 36409;
  localparam longint BRK7 = 50972;
  localparam longint BRK8 = 58254;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // index[11:0], sample[28:12]
  logic [MODE_W-1:0]     in_tuser;   // mode[1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // red[7:0], green[15:8], blue[23:16]
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  logic signed [16:0] line_store [0:4095];
  bit                 slot_loaded [0:4095];
  int                 loaded_slots [$];
  logic [28:0]        line_sum;
  logic               reg_auto;
  logic signed [16:0] reg_low;
  logic signed [16:0] reg_high;
  logic signed [16:0] reg_offset;
  logic [11:0]        reg_pan;
  logic [12:0]        reg_width;

  rgb_t pending_pixels [$];
  int   mismatches = 0;
  int   in_quiet   = 0;
  int   out_quiet  = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  spectrum_waterfall_colormap i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // idle cycles before the next request; occasional runs with no idling
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic int width_eff();
    if (reg_width == 0) return 1;
    if (reg_width > 4096) return 4096;
    return reg_width;
  endfunction

  function automatic rgb_t make_rgb(longint r, longint g, longint b);
    rgb_t c;
    c.red   = 8'(r);
    c.green = 8'(g);
    c.blue  = 8'(b);
    return c;
  endfunction

  function automatic longint seg_pos(longint f, longint b, bit half);
    longint lp;
    lp = (f - b) * 9;
    if (half) lp = lp / 2;
    if (lp > UNIT_Q16) lp = UNIT_Q16;
    return lp;
  endfunction

  function automatic longint ramp_up(longint lp);
    return (lp * 255) >> 16;
  endfunction

  function automatic longint ramp_down(longint lp);
    return ((UNIT_Q16 - lp) * 255) >> 16;
  endfunction

  function automatic rgb_t palette_colour(longint f);
    longint lp;
    if (f < BRK2) begin
      lp = seg_pos(f, 0, 1'b1);
      return make_rgb(0, 0, ramp_up(lp));
    end
    if (f < BRK3) begin
      lp = seg_pos(f, BRK2, 1'b0);
      return make_rgb(0, ramp_up(lp), 255);
    end
    if (f < BRK4) begin
      lp = seg_pos(f, BRK3, 1'b0);
      return make_rgb(0, 255, ramp_down(lp));
    end
    if (f < BRK5) begin
      lp = seg_pos(f, BRK4, 1'b0);
      return make_rgb(ramp_up(lp), 255, 0);
    end
    if (f < BRK7) begin
      lp = seg_pos(f, BRK5, 1'b1);
      return make_rgb(255, ramp_down(lp), 0);
    end
    if (f < BRK8) begin
      lp = seg_pos(f, BRK7, 1'b0);
      return make_rgb(255, 0, ramp_up(lp));
    end
    lp = seg_pos(f, BRK8, 1'b0);
    return make_rgb(((4 * UNIT_Q16 - lp) * 255) >> 18, (lp * 255) >> 17, 255);
  endfunction

  function automatic rgb_t pixel_colour(logic [11:0] col);
    logic [11:0] addr;
    longint off, low, high, v, n, s, mean, f;
    addr = col + reg_pan;
    off  = reg_offset;
    if (reg_auto) begin
      s    = $signed(line_sum);
      n    = width_eff();
      mean = (s >= 0) ? s / n : -((-s + n - 1) / n);
      low  = mean + off - LOW_MARGIN;
      high = low + SPAN_Q8;
    end else begin
      low  = reg_low;
      high = reg_high;
    end
    v = line_store[addr] + off;
    if (v < low) return make_rgb(0, 0, 0);
    if (v > high) return make_rgb(255, 255, 0);
    f = (high == low) ? 0 : ((v - low) << 16) / (high - low);
    return palette_colour(f);
  endfunction

  task automatic track_request(logic [MODE_W-1:0] m, logic [11:0] idx, logic [16:0] smp);
    case (m)
      MODE_LOAD: begin
        line_store[idx] = smp;
        if (!slot_loaded[idx]) loaded_slots.push_back(idx);
        slot_loaded[idx] = 1'b1;
        if (idx < width_eff()) line_sum = line_sum + {{12{smp[16]}}, smp};
      end
      MODE_PIXEL: pending_pixels.push_back(pixel_colour(idx));
      MODE_CLEAR: line_sum = '0;
      default: ;
    endcase
  endtask

  task automatic send_request(logic [MODE_W-1:0] m, logic [11:0] idx, logic [16:0] smp);
    int gap;
    @(negedge clk);
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {3'b000, smp, idx};
    do @(posedge clk); while (in_tready !== 1'b1);
    track_request(m, idx, smp);
  endtask

  task automatic load_slot(int slot, logic [16:0] value);
    send_request(MODE_LOAD, 12'(slot), value);
  endtask

  task automatic request_pixel_of(int slot);
    send_request(MODE_PIXEL, 12'(slot - reg_pan), 17'($urandom));
  endtask

  // stop sending and let every pixel drain before touching registers
  task automatic quiesce();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [16:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (r)
      REG_AUTO_LEVEL:   reg_auto   = value[0];
      REG_MANUAL_LOW:   reg_low    = value;
      REG_MANUAL_HIGH:  reg_high   = value;
      REG_LEVEL_OFFSET: reg_offset = value;
      REG_PAN_OFFSET:   reg_pan    = value[11:0];
      REG_LINE_WIDTH:   reg_width  = value[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [16:0] near_level(int lo, int hi);
    int v;
    v = lo + int'($urandom_range(0, hi - lo));
    if (v < -65536) v = -65536;
    if (v > 65535) v = 65535;
    return 17'(v);
  endfunction

  // reset limits: low, high, beyond both, plus clear and the unused mode
  task automatic test_reset_defaults();
    load_slot(0, -17'sd35840);
    load_slot(1, -17'sd15360);
    load_slot(2, -17'sd25600);
    load_slot(3, -17'sd65536);
    load_slot(4095, 17'sd65535);
    request_pixel_of(0);
    request_pixel_of(1);
    request_pixel_of(2);
    request_pixel_of(3);
    request_pixel_of(4095);
    send_request(MODE_CLEAR, 12'hFFF, 17'h1FFFF);
    send_request(MODE_UNUSED, 12'hABC, 17'h15555);
  endtask

  // range of exactly 1.0 so the fraction equals the offset from low
  task automatic test_palette_edges();
    int edge_pts [22];
    edge_pts = '{0, 7000, 14563, 14564, 18000, 21844, 21845, 25000, 29126, 29127, 33000,
                 36408, 36409, 43000, 50971, 50972, 55000, 58253, 58254, 62000, 65535, 65536};
    quiesce();
    write_reg(REG_MANUAL_LOW, -17'sd32768);
    write_reg(REG_MANUAL_HIGH, 17'sd32768);
    for (int i = 0; i < 22; i++) begin
      load_slot(64 + i, 17'(edge_pts[i] - 32768));
      request_pixel_of(64 + i);
    end
  endtask

  task automatic test_limit_corners();
    quiesce();
    write_reg(REG_MANUAL_LOW, 17'sd1000);
    write_reg(REG_MANUAL_HIGH, 17'sd1000);
    load_slot(10, 17'sd1000);
    load_slot(11, 17'sd999);
    load_slot(12, 17'sd1001);
    request_pixel_of(10);
    request_pixel_of(11);
    request_pixel_of(12);
    // inverted limits
    quiesce();
    write_reg(REG_MANUAL_LOW, 17'sd5000);
    write_reg(REG_MANUAL_HIGH, -17'sd5000);
    load_slot(13, 17'sd0);
    load_slot(14, 17'sd6000);
    request_pixel_of(13);
    request_pixel_of(14);
    quiesce();
    write_reg(REG_MANUAL_LOW, -17'sd65536);
    write_reg(REG_MANUAL_HIGH, 17'sd65535);
    write_reg(REG_LEVEL_OFFSET, 17'sd65535);
    request_pixel_of(4095);
    request_pixel_of(3);
    quiesce();
    write_reg(REG_LEVEL_OFFSET, -17'sd65536);
    request_pixel_of(3);
    request_pixel_of(4095);
    quiesce();
    write_reg(REG_LEVEL_OFFSET, 17'sd0);
    write_reg(REG_MANUAL_LOW, 17'sd65535);
    write_reg(REG_MANUAL_HIGH, 17'sd65535);
    request_pixel_of(4095);
    quiesce();
    write_reg(REG_MANUAL_LOW, -17'sd65536);
    write_reg(REG_MANUAL_HIGH, -17'sd65536);
    request_pixel_of(3);
    // read address wraps past the top of the store
    quiesce();
    write_reg(REG_MANUAL_HIGH, 17'sd65535);
    write_reg(REG_PAN_OFFSET, 17'd4095);
    load_slot(4094, 17'sd12345);
    send_request(MODE_PIXEL, 12'd1, 17'h0);
    send_request(MODE_PIXEL, 12'd0, 17'h1FFFF);
    send_request(MODE_PIXEL, 12'd4095, 17'h0AAAA);
  endtask

  task automatic test_auto_level();
    quiesce();
    write_reg(REG_PAN_OFFSET, 17'd0);
    write_reg(REG_AUTO_LEVEL, 17'd1);
    write_reg(REG_LINE_WIDTH, 17'd0);
    send_request(MODE_CLEAR, 12'd0, 17'd0);
    load_slot(0, 17'sd2560);
    load_slot(1, 17'sd3000);
    request_pixel_of(0);
    request_pixel_of(1);
    quiesce();
    write_reg(REG_LINE_WIDTH, 17'd8191);
    send_request(MODE_CLEAR, 12'd0, 17'd0);
    load_slot(4095, 17'sd40960);
    load_slot(100, 17'sd5000);
    request_pixel_of(4095);
    request_pixel_of(100);
    // negative mean rounds towards minus infinity
    quiesce();
    write_reg(REG_LINE_WIDTH, 17'd3);
    write_reg(REG_LEVEL_OFFSET, -17'sd300);
    send_request(MODE_CLEAR, 12'd0, 17'd0);
    load_slot(0, -17'sd1);
    load_slot(1, -17'sd1);
    load_slot(2, -17'sd2);
    request_pixel_of(0);
    request_pixel_of(1);
    request_pixel_of(2);
    quiesce();
    write_reg(REG_LINE_WIDTH, 17'd4096);
    write_reg(REG_LEVEL_OFFSET, 17'sd300);
    send_request(MODE_CLEAR, 12'd0, 17'd0);
    load_slot(17, -17'sd20000);
    request_pixel_of(17);
  endtask

  task automatic test_random_lines();
    int sent, w, n, lo, hi, off, base, slot, pix;
    bit auto_mode;
    int line_slots [$];
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiesce();
      auto_mode = $urandom_range(0, 1);
      case ($urandom_range(0, 7))
        0:       w = 0;
        1:       w = $urandom_range(4097, 8191);
        2:       w = 4096;
        default: w = $urandom_range(1, 48);
      endcase
      if ($urandom_range(0, 5) == 0) off = int'($urandom_range(0, 131071)) - 65536;
      else off = int'($urandom_range(0, 4000)) - 2000;
      lo   = int'($urandom_range(0, 60000)) - 40000;
      hi   = lo + int'($urandom_range(0, 30000));
      base = int'($urandom_range(0, 60000)) - 30000;
      write_reg(REG_AUTO_LEVEL, 17'(auto_mode));
      write_reg(REG_LINE_WIDTH, 17'(w));
      write_reg(REG_PAN_OFFSET, 17'($urandom_range(0, 4095)));
      write_reg(REG_LEVEL_OFFSET, 17'(off));
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_MANUAL_LOW, 17'(hi));
        write_reg(REG_MANUAL_HIGH, 17'(lo));
      end else begin
        write_reg(REG_MANUAL_LOW, 17'(lo));
        write_reg(REG_MANUAL_HIGH, 17'(hi));
      end

      send_request(MODE_CLEAR, 12'($urandom), 17'($urandom));
      sent++;
      line_slots.delete();
      n = (w >= 1 && w <= 48) ? w : $urandom_range(8, 40);
      for (int k = 0; k < n; k++) begin
        slot = (w >= 1 && w <= 48) ? k : $urandom_range(0, 4095);
        if (auto_mode) load_slot(slot, near_level(base - 3000, base + 11000));
        else load_slot(slot, near_level(lo - off - 2000, hi - off + 2000));
        line_slots.push_back(slot);
        sent++;
      end

      pix = $urandom_range(n, 2 * n);
      for (int k = 0; k < pix; k++) begin
        case ($urandom_range(0, 9))
          0: begin
            load_slot($urandom_range(0, 4095), 17'($urandom));
            sent++;
          end
          1: send_request(MODE_UNUSED, 12'($urandom), 17'($urandom));
          2: begin
            request_pixel_of(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
            sent++;
          end
          default: begin
            request_pixel_of(line_slots[$urandom_range(0, line_slots.size() - 1)]);
            sent++;
          end
        endcase
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    line_sum   = '0;
    reg_auto   = 1'b0;
    reg_low    = -17'sd35840;
    reg_high   = -17'sd15360;
    reg_offset = '0;
    reg_pan    = '0;
    reg_width  = 13'd4096;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_palette_edges();
    test_limit_corners();
    test_auto_level();
    test_random_lines();
    quiesce();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : pixel_sink
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = draw_gap(out_quiet);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : pixel_check
    rgb_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, got %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata[7:0] !== want.red) begin
          $display("%0t: red expected %0d, got %0d", $time, want.red, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[15:8] !== want.green) begin
          $display("%0t: green expected %0d, got %0d", $time, want.green, out_tdata[15:8]);
          mismatches++;
        end
        if (out_tdata[23:16] !== want.blue) begin
          $display("%0t: blue expected %0d, got %0d", $time, want.blue, out_tdata[23:16]);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
